// File: hw/rtl/lapy_pkg.sv
`default_nettype none
package lapy_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int DATA_W = 56;
   localparam int ANGLE_W = 35;
   localparam int PRESCALE = 20;
   localparam logic [29:0] INV_GAIN = 30'd652032874;
   localparam logic signed [ANGLE_W-1:0] PI_Q30 = 35'sd3373259426;
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = 35'sd1686629713;

   typedef struct packed {
      logic signed [31:0] object_x;
      logic signed [31:0] object_y;
      logic signed [31:0] object_z;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic               updated;
   } rsp_type;

   typedef struct packed {
      logic all_zero;
      logic dy_zero;
      logic dy_neg;
      logic dx_zero;
      logic dx_neg;
      logic dz_zero;
      logic dz_neg;
   } flags_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  x;
      logic signed [DATA_W-1:0]  y;
      logic signed [ANGLE_W-1:0] z;
      logic signed [ANGLE_W-1:0] base;
      logic signed [DATA_W-1:0]  dy_s;
      flags_type                 flags;
   } lane_type;

   // atan(2^-i) in Q0.30, fraction dropped
   function automatic logic [29:0] atan_q30(input int idx);
      logic [29:0] v;
      case (idx)
         0:  v = 30'd843314856;
         1:  v = 30'd497837829;
         2:  v = 30'd263043836;
         3:  v = 30'd133525158;
         4:  v = 30'd67021686;
         5:  v = 30'd33543515;
         6:  v = 30'd16775850;
         7:  v = 30'd8388437;
         8:  v = 30'd4194282;
         9:  v = 30'd2097149;
         10: v = 30'd1048575;
         11: v = 30'd524287;
         12: v = 30'd262143;
         13: v = 30'd131071;
         14: v = 30'd65535;
         15: v = 30'd32767;
         16: v = 30'd16383;
         17: v = 30'd8191;
         18: v = 30'd4095;
         19: v = 30'd2047;
         20: v = 30'd1023;
         21: v = 30'd511;
         22: v = 30'd255;
         23: v = 30'd127;
         24: v = 30'd63;
         25: v = 30'd31;
         26: v = 30'd15;
         27: v = 30'd7;
         28: v = 30'd3;
         29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lapy_cell.sv
`default_nettype none
module lapy_cell #(
   parameter int SHIFT = 0
) (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic in_valid,
   input  wire lapy_pkg::lane_type in_lane,
   output logic               in_stall,
   output logic               out_valid,
   output lapy_pkg::lane_type out_lane,
   input  wire                logic out_stall
);

   localparam logic signed [lapy_pkg::ANGLE_W-1:0] ATAN =
      signed'({{(lapy_pkg::ANGLE_W-30){1'b0}}, lapy_pkg::atan_q30(SHIFT)});

   logic               valid_ff;
   lapy_pkg::lane_type lane_ff;
   lapy_pkg::lane_type lane_in;
   logic signed [lapy_pkg::DATA_W-1:0] xs;
   logic signed [lapy_pkg::DATA_W-1:0] ys;

   // one vectoring micro-rotation: drive y toward zero
   always_comb begin
      xs = in_lane.x >>> SHIFT;
      ys = in_lane.y >>> SHIFT;
      lane_in = in_lane;
      if (!in_lane.y[lapy_pkg::DATA_W-1]) begin
         lane_in.x = in_lane.x + ys;
         lane_in.y = in_lane.y - xs;
         lane_in.z = in_lane.z + ATAN;
      end else begin
         lane_in.x = in_lane.x - ys;
         lane_in.y = in_lane.y + xs;
         lane_in.z = in_lane.z - ATAN;
      end
   end

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         lane_ff <= lane_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lapy_gain.sv
`default_nettype none
module lapy_gain (
   input  wire                logic clock,
   input  wire                logic reset,
   input  wire                logic in_valid,
   input  wire lapy_pkg::lane_type in_lane,
   output logic               in_stall,
   output logic               out_valid,
   output lapy_pkg::lane_type out_lane,
   input  wire                logic out_stall
);

   localparam int W = lapy_pkg::DATA_W;

   logic               a_valid_ff;
   logic               b_valid_ff;
   logic               a_stall;
   logic               b_stall;
   logic [W-1:0]       hi_prod_ff;
   logic [59:0]        lo_prod_ff;
   lapy_pkg::lane_type a_lane_ff;
   lapy_pkg::lane_type a_lane_in;
   lapy_pkg::lane_type b_lane_ff;
   lapy_pkg::lane_type b_lane_in;
   logic [W-1:0]       h;

   assign b_stall   = b_valid_ff && out_stall;
   assign a_stall   = a_valid_ff && b_stall;
   assign in_stall  = a_stall;
   assign out_valid = b_valid_ff;
   assign out_lane  = b_lane_ff;

   // keep the yaw angle aside as base
   always_comb begin
      a_lane_in      = in_lane;
      a_lane_in.base = in_lane.z;
   end

   // sum partial products; load pitch rotation (x = h, y = dy, angle of yaw kept)
   always_comb begin
      h = hi_prod_ff + {{(W-30){1'b0}}, lo_prod_ff[59:30]};
      b_lane_in   = a_lane_ff;
      b_lane_in.x = signed'(h);
      b_lane_in.y = a_lane_ff.dy_s;
      b_lane_in.z = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (!a_stall) begin
            a_valid_ff <= in_valid;
         end
         if (!b_stall) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!a_stall && in_valid) begin
         hi_prod_ff  <= W'(in_lane.x[W-1:30] * lapy_pkg::INV_GAIN);
         lo_prod_ff  <= in_lane.x[29:0] * lapy_pkg::INV_GAIN;
         a_lane_ff   <= a_lane_in;
      end
      if (!b_stall && a_valid_ff) begin
         b_lane_ff <= b_lane_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/look_at_pitch_yaw.sv
`default_nettype none
// Look-at angles: each request beat carries an object and a target position
// (signed Q16.16); the response beat gives pitch and yaw in signed Q4.12
// radians, with updated low (and both angles zero) when the two positions
// coincide. The block is a fully pipelined engine: one beat is accepted per
// cycle while req_stall is low, and each beat passes from acceptance to
// response through one difference stage, a row of CORDIC_STAGES vectoring cells for
// the horizontal distance and yaw angle, two gain-correction stages, a second
// row of CORDIC_STAGES cells for pitch, and one output stage. Every stage stalls
// only when its own successor is full, so empty slots in the row are squeezed
// out and requests keep flowing while a finished response waits.
module look_at_pitch_yaw #(
   parameter int CORDIC_STAGES = lapy_pkg::CORDIC_STAGES_DEF
) (
   input  wire              logic clock,
   input  wire              logic reset,
   input  wire              logic req_valid,
   output logic             req_stall,
   input  wire lapy_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              logic rsp_stall,
   output lapy_pkg::rsp_type rsp_data
);

   localparam int W  = lapy_pkg::DATA_W;
   localparam int AW = lapy_pkg::ANGLE_W;

   // front stage: differences, magnitudes, prescale
   logic               f_valid_ff;
   logic               f_stall;
   lapy_pkg::lane_type f_lane_ff;
   lapy_pkg::lane_type f_lane_in;
   logic signed [32:0] dx;
   logic signed [32:0] dy;
   logic signed [32:0] dz;
   logic signed [W-1:0] dx_w;
   logic signed [W-1:0] dy_w;
   logic signed [W-1:0] dz_w;

   always_comb begin
      dx = {req_data.object_x[31], req_data.object_x} - {req_data.target_x[31], req_data.target_x};
      dy = {req_data.object_y[31], req_data.object_y} - {req_data.target_y[31], req_data.target_y};
      dz = {req_data.object_z[31], req_data.object_z} - {req_data.target_z[31], req_data.target_z};
      dx_w = W'(dx);
      dy_w = W'(dy);
      dz_w = W'(dz);
      f_lane_in.flags.dx_zero  = (dx == '0);
      f_lane_in.flags.dy_zero  = (dy == '0);
      f_lane_in.flags.dz_zero  = (dz == '0);
      f_lane_in.flags.dx_neg   = dx[32];
      f_lane_in.flags.dy_neg   = dy[32];
      f_lane_in.flags.dz_neg   = dz[32];
      f_lane_in.flags.all_zero = (dx == '0) && (dy == '0) && (dz == '0);
      // yaw rotation starts at (|dz|, |dx|)
      f_lane_in.x    = (dz[32] ? -dz_w : dz_w) <<< lapy_pkg::PRESCALE;
      f_lane_in.y    = (dx[32] ? -dx_w : dx_w) <<< lapy_pkg::PRESCALE;
      f_lane_in.z    = '0;
      f_lane_in.base = '0;
      f_lane_in.dy_s = dy_w <<< lapy_pkg::PRESCALE;
   end

   // stall chain: nodes 0..CORDIC_STAGES for the yaw row and for the pitch row
   logic               y_valid [CORDIC_STAGES+1];
   logic               y_stall [CORDIC_STAGES+1];
   lapy_pkg::lane_type y_lane  [CORDIC_STAGES+1];
   logic               p_valid [CORDIC_STAGES+1];
   logic               p_stall [CORDIC_STAGES+1];
   lapy_pkg::lane_type p_lane  [CORDIC_STAGES+1];

   assign req_stall  = f_stall;
   assign f_stall    = f_valid_ff && y_stall[0];
   assign y_valid[0] = f_valid_ff;
   assign y_lane[0]  = f_lane_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (!f_stall) begin
         f_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!f_stall && req_valid) begin
         f_lane_ff <= f_lane_in;
      end
   end

   // yaw / horizontal magnitude row
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_yaw
      lapy_cell #(.SHIFT(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (y_valid[i]),
         .in_lane   (y_lane[i]),
         .in_stall  (y_stall[i]),
         .out_valid (y_valid[i+1]),
         .out_lane  (y_lane[i+1]),
         .out_stall (y_stall[i+1])
      );
   end

   // remove CORDIC gain from the horizontal magnitude
   lapy_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (y_valid[CORDIC_STAGES]),
      .in_lane   (y_lane[CORDIC_STAGES]),
      .in_stall  (y_stall[CORDIC_STAGES]),
      .out_valid (p_valid[0]),
      .out_lane  (p_lane[0]),
      .out_stall (p_stall[0])
   );

   // pitch row
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pitch
      lapy_cell #(.SHIFT(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (p_valid[i]),
         .in_lane   (p_lane[i]),
         .in_stall  (p_stall[i]),
         .out_valid (p_valid[i+1]),
         .out_lane  (p_lane[i+1]),
         .out_stall (p_stall[i+1])
      );
   end

   // output stage: special cases, quadrant fix, rounding
   logic               o_valid_ff;
   lapy_pkg::rsp_type  o_data_ff;
   lapy_pkg::rsp_type  o_data_in;
   lapy_pkg::lane_type e;
   logic signed [AW-1:0] pitch;
   logic signed [AW-1:0] yaw;

   function automatic logic [15:0] round_q412(input logic signed [AW-1:0] v);
      logic [AW-1:0] mag;
      logic [AW-1:0] r;
      mag = v[AW-1] ? AW'(-v) : AW'(v);
      r   = (mag + AW'(18'h20000)) >> 18;
      return v[AW-1] ? 16'(-r) : r[15:0];
   endfunction

   assign e = p_lane[CORDIC_STAGES];
   assign p_stall[CORDIC_STAGES] = o_valid_ff && rsp_stall;

   always_comb begin
      if (e.flags.dy_zero) begin
         pitch = '0;
      end else if (e.flags.dx_zero && e.flags.dz_zero) begin
         pitch = e.flags.dy_neg ? -lapy_pkg::HALF_PI_Q30 : lapy_pkg::HALF_PI_Q30;
      end else begin
         pitch = e.z;
      end
      if (e.flags.dx_zero) begin
         yaw = '0;
      end else if (e.flags.dz_zero) begin
         yaw = e.flags.dx_neg ? -lapy_pkg::HALF_PI_Q30 : lapy_pkg::HALF_PI_Q30;
      end else begin
         yaw = (e.flags.dx_neg != e.flags.dz_neg) ? -e.base : e.base;
      end
      if (!e.flags.dz_neg && !e.flags.dz_zero) begin
         yaw = yaw + lapy_pkg::PI_Q30;
      end
      if (e.flags.all_zero) begin
         o_data_in = '0;
      end else begin
         o_data_in.pitch_angle = signed'(round_q412(pitch));
         o_data_in.yaw_angle   = signed'(round_q412(yaw));
         o_data_in.updated     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (!p_stall[CORDIC_STAGES]) begin
         o_valid_ff <= p_valid[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (!p_stall[CORDIC_STAGES] && p_valid[CORDIC_STAGES]) begin
         o_data_ff <= o_data_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

endmodule
`default_nettype wire
